// ===== hw/rtl/bpc_pkg.sv =====
// ----------------------------------------------------------------------------
// Button press classifier package
// Shared widths, codes and types for the push-switch press classifier.
// ----------------------------------------------------------------------------
package bpc_pkg;

   localparam int TIMER_BITS_DEF = 16;
   localparam int CFG_W          = 16;
   localparam int CSR_IDX_W      = 2;
   localparam int ELAPSED_W      = 10;
   localparam int CODE_W         = 3;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_ACTIVE_LEVEL = 2'd0,
      REG_RELEASE_HOLD = 2'd1,
      REG_LONG_PRESS   = 2'd2,
      REG_EXTRA_LONG   = 2'd3
   } csr_index_type;

   typedef enum logic [CODE_W-1:0] {
      EV_NONE        = 3'd0,
      EV_PRESS_START = 3'd1,
      EV_SHORT_PRESS = 3'd2,
      EV_LONG_START  = 3'd3,
      EV_LONG_END    = 3'd4,
      EV_XLONG_START = 3'd5,
      EV_XLONG_END   = 3'd6
   } event_type;

   typedef enum logic [CODE_W-1:0] {
      PH_IDLE      = 3'd0,
      PH_PRESSED   = 3'd1,
      PH_RELEASED  = 3'd2,
      PH_LONG      = 3'd3,
      PH_LONG_END  = 3'd4,
      PH_XLONG     = 3'd5,
      PH_XLONG_END = 3'd6
   } phase_type;

   typedef struct packed {
      logic             active_level;
      logic [CFG_W-1:0] release_hold_ms;
      logic [CFG_W-1:0] long_press_ms;
      logic [CFG_W-1:0] extra_long_ms;
   } cfg_type;

endpackage

// ===== hw/rtl/bpc_ifs.sv =====
// ----------------------------------------------------------------------------
// Button press classifier channels
// Valid/ready channels for scan words in and classification words out.
// ----------------------------------------------------------------------------
interface bpc_req_if;
   logic                           valid;
   logic                           ready;
   logic                           switch_level;
   logic [bpc_pkg::ELAPSED_W-1:0]  ms_elapsed;

   modport source (output valid, output switch_level, output ms_elapsed, input ready);
   modport sink   (input valid, input switch_level, input ms_elapsed, output ready);
endinterface

interface bpc_rsp_if;
   logic                        valid;
   logic                        ready;
   logic [bpc_pkg::CODE_W-1:0]  event_code;
   logic [bpc_pkg::CODE_W-1:0]  press_state;

   modport source (output valid, output event_code, output press_state, input ready);
   modport sink   (input valid, input event_code, input press_state, output ready);
endinterface

// ===== hw/rtl/bpc_csr.sv =====
// ----------------------------------------------------------------------------
// Button press classifier control registers
// Holds the active level and the three timing thresholds.
// ----------------------------------------------------------------------------
module bpc_csr (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_wr_en,
   input  logic [bpc_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [bpc_pkg::CFG_W-1:0]      csr_wdata,
   output bpc_pkg::cfg_type               cfg
);
   import bpc_pkg::*;

   cfg_type cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.active_level    <= 1'b0;
         cfg_ff.release_hold_ms <= CFG_W'(50);
         cfg_ff.long_press_ms   <= CFG_W'(800);
         cfg_ff.extra_long_ms   <= '0;
      end else if (csr_wr_en) begin
         case (csr_index)
            REG_ACTIVE_LEVEL: cfg_ff.active_level    <= csr_wdata[0];
            REG_RELEASE_HOLD: cfg_ff.release_hold_ms <= csr_wdata;
            REG_LONG_PRESS:   cfg_ff.long_press_ms   <= csr_wdata;
            REG_EXTRA_LONG:   cfg_ff.extra_long_ms   <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   assign cfg = cfg_ff;

endmodule

// ===== hw/rtl/bpc_engine.sv =====
// ----------------------------------------------------------------------------
// Button press classifier engine
// Phase and hold timer registers with the per-scan transition logic.
// ----------------------------------------------------------------------------
module bpc_engine #(
   parameter int TIMER_BITS = bpc_pkg::TIMER_BITS_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           advance,
   input  logic                           switch_level,
   input  logic [bpc_pkg::ELAPSED_W-1:0]  ms_elapsed,
   input  bpc_pkg::cfg_type               cfg,
   output logic [bpc_pkg::CODE_W-1:0]     event_code_in,
   output logic [bpc_pkg::CODE_W-1:0]     press_state_in
);
   import bpc_pkg::*;

   localparam int SUM_BITS = ((TIMER_BITS > ELAPSED_W) ? TIMER_BITS : ELAPSED_W) + 1;
   localparam int CMP_BITS = (TIMER_BITS > CFG_W) ? TIMER_BITS : CFG_W;

   phase_type               phase_ff, phase_in;
   logic [TIMER_BITS-1:0]   timer_ff, timer_in;
   event_type               event_in;
   logic [SUM_BITS-1:0]     sum;
   logic [TIMER_BITS-1:0]   t;
   logic [CMP_BITS-1:0]     t_cmp;
   logic                    active;
   logic                    over_release;
   logic                    over_long;
   logic                    over_xlong;

   always_comb begin
      active       = (switch_level == cfg.active_level);
      sum          = SUM_BITS'(timer_ff) + SUM_BITS'(ms_elapsed);
      t            = (sum > SUM_BITS'({TIMER_BITS{1'b1}})) ? {TIMER_BITS{1'b1}}
                                                           : sum[TIMER_BITS-1:0];
      t_cmp        = CMP_BITS'(t);
      over_release = t_cmp > CMP_BITS'(cfg.release_hold_ms);
      over_long    = t_cmp > CMP_BITS'(cfg.long_press_ms);
      over_xlong   = (cfg.extra_long_ms != '0) && (t_cmp > CMP_BITS'(cfg.extra_long_ms));

      phase_in = phase_ff;
      timer_in = t;
      event_in = EV_NONE;
      case (phase_ff)
         PH_IDLE: begin
            if (active) begin
               phase_in = PH_PRESSED;
               timer_in = '0;
               event_in = EV_PRESS_START;
            end
         end
         PH_PRESSED: begin
            if (!active) begin
               phase_in = PH_RELEASED;
               timer_in = '0;
            end else if (over_long) begin
               phase_in = PH_LONG;
               event_in = EV_LONG_START;
            end
         end
         PH_RELEASED: begin
            if (!active && over_release) begin
               phase_in = PH_IDLE;
               timer_in = '0;
               event_in = EV_SHORT_PRESS;
            end
         end
         PH_LONG: begin
            if (!active) begin
               phase_in = PH_LONG_END;
               timer_in = '0;
            end else if (over_xlong) begin
               phase_in = PH_XLONG;
               event_in = EV_XLONG_START;
            end
         end
         PH_LONG_END: begin
            phase_in = PH_IDLE;
            timer_in = '0;
            event_in = EV_LONG_END;
         end
         PH_XLONG: begin
            if (!active) begin
               phase_in = PH_XLONG_END;
               timer_in = '0;
            end
         end
         PH_XLONG_END: begin
            phase_in = PH_IDLE;
            timer_in = '0;
            event_in = EV_XLONG_END;
         end
         default: begin
            phase_in = PH_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         timer_ff <= '0;
      end else if (advance) begin
         phase_ff <= phase_in;
         timer_ff <= timer_in;
      end
   end

   assign event_code_in  = CODE_W'(event_in);
   assign press_state_in = CODE_W'(phase_in);

endmodule

// ===== hw/rtl/button_press_classifier.sv =====
// ----------------------------------------------------------------------------
// Button press classifier
// Classifies push-switch scans into press, short, long and extra-long events.
// Path: input register for the scan word, then output register for its result word.
// Throughput: one scan word per cycle while the result channel is not stalled.
// Reset: synchronous; idle phase, zero timer, registers at their defaults.
// ----------------------------------------------------------------------------
module button_press_classifier #(
   parameter int TIMER_BITS = bpc_pkg::TIMER_BITS_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   bpc_req_if.sink                        req,
   bpc_rsp_if.source                      rsp,
   input  logic                           csr_wr_en,
   input  logic [bpc_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [bpc_pkg::CFG_W-1:0]      csr_wdata
);
   import bpc_pkg::*;

   cfg_type                 cfg;
   logic                    in_valid_ff;
   logic                    in_switch_ff;
   logic [ELAPSED_W-1:0]    in_elapsed_ff;
   logic                    rsp_valid_ff;
   logic [CODE_W-1:0]       rsp_event_ff, rsp_event_in;
   logic [CODE_W-1:0]       rsp_state_ff, rsp_state_in;
   logic                    advance;

   assign advance   = in_valid_ff && (!rsp_valid_ff || rsp.ready);
   assign req.ready = !in_valid_ff || advance;

   bpc_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   bpc_engine #(
      .TIMER_BITS (TIMER_BITS)
   ) u_engine (
      .clock          (clock),
      .reset          (reset),
      .advance        (advance),
      .switch_level   (in_switch_ff),
      .ms_elapsed     (in_elapsed_ff),
      .cfg            (cfg),
      .event_code_in  (rsp_event_in),
      .press_state_in (rsp_state_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req.ready) begin
         in_valid_ff <= req.valid;
      end
      if (req.valid && req.ready) begin
         in_switch_ff  <= req.switch_level;
         in_elapsed_ff <= req.ms_elapsed;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (!rsp_valid_ff || rsp.ready) begin
         rsp_valid_ff <= in_valid_ff;
      end
      if (advance) begin
         rsp_event_ff <= rsp_event_in;
         rsp_state_ff <= rsp_state_in;
      end
   end

   assign rsp.valid       = rsp_valid_ff;
   assign rsp.event_code  = rsp_event_ff;
   assign rsp.press_state = rsp_state_ff;

   a_reset_empty : assert property (@(posedge clock)
      $past(reset) |-> (!rsp.valid && !in_valid_ff))
      else $error("words present straight after reset");

   a_stall_only_when_full : assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && !advance) |-> (rsp.valid && !rsp.ready))
      else $error("input stage held without an output stall");

   a_state_code_used : assert property (@(posedge clock) disable iff (reset)
      rsp.valid |-> (rsp.press_state != 3'd7))
      else $error("unused phase code reported");

   a_press_start_state : assert property (@(posedge clock) disable iff (reset)
      (rsp.valid && rsp.event_code == EV_PRESS_START) |-> (rsp.press_state == PH_PRESSED))
      else $error("press start reported outside pressed phase");

   a_end_events_idle : assert property (@(posedge clock) disable iff (reset)
      (rsp.valid && (rsp.event_code == EV_SHORT_PRESS || rsp.event_code == EV_LONG_END
                     || rsp.event_code == EV_XLONG_END))
      |-> (rsp.press_state == PH_IDLE))
      else $error("closing event reported outside idle phase");

endmodule

// ===== verif/tb_top.sv =====
// ----------------------------------------------------------------------------
// Button press classifier testbench
// Drives switch scan words with random gaps, stalls the result channel in
// random bursts and checks every classification word against a predictor of
// the phase machine and saturating hold timer, across several register
// settings including the extremes.
// ----------------------------------------------------------------------------
module tb_top;
   import bpc_pkg::*;

   localparam int TIMER_BITS     = TIMER_BITS_DEF;
   localparam int WATCHDOG_LIMIT = 1000;

   typedef struct {
      event_type ev;
      phase_type ph;
   } press_class_type;

   logic          clock;
   logic          reset;
   logic          csr_wr_en;
   csr_index_type csr_index;
   logic [CFG_W-1:0] csr_wdata;

   bpc_req_if req_if ();
   bpc_rsp_if rsp_if ();

   button_press_classifier u_top (
      .clock     (clock),
      .reset     (reset),
      .req       (req_if),
      .rsp       (rsp_if),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   logic                  pred_active_level;
   logic [CFG_W-1:0]      pred_release_hold;
   logic [CFG_W-1:0]      pred_long_press;
   logic [CFG_W-1:0]      pred_extra_long;
   phase_type             pred_phase;
   logic [TIMER_BITS-1:0] pred_hold_timer;
   press_class_type       expected_class[$];
   int                    error_count = 0;
   bit                    idle_on = 1'b1;

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   task automatic report_mismatch(input string what, input int got, input int want);
      $display("mismatch: %s got %0d want %0d", what, got, want);
      error_count++;
   endtask

   function automatic void classify_scan(input logic level, input logic [ELAPSED_W-1:0] ms);
      bit                  active;
      logic [TIMER_BITS:0] sum;
      event_type           ev;
      active = (level == pred_active_level);
      sum = {1'b0, pred_hold_timer} + ms;
      pred_hold_timer = sum[TIMER_BITS] ? '1 : sum[TIMER_BITS-1:0];
      ev = EV_NONE;
      case (pred_phase)
         PH_IDLE: begin
            if (active) begin
               pred_phase = PH_PRESSED;
               pred_hold_timer = '0;
               ev = EV_PRESS_START;
            end
         end
         PH_PRESSED: begin
            if (!active) begin
               pred_phase = PH_RELEASED;
               pred_hold_timer = '0;
            end else if (pred_hold_timer > pred_long_press) begin
               pred_phase = PH_LONG;
               ev = EV_LONG_START;
            end
         end
         PH_RELEASED: begin
            if (!active && pred_hold_timer > pred_release_hold) begin
               pred_phase = PH_IDLE;
               pred_hold_timer = '0;
               ev = EV_SHORT_PRESS;
            end
         end
         PH_LONG: begin
            if (!active) begin
               pred_phase = PH_LONG_END;
               pred_hold_timer = '0;
            end else if (pred_extra_long != 0 && pred_hold_timer > pred_extra_long) begin
               pred_phase = PH_XLONG;
               ev = EV_XLONG_START;
            end
         end
         PH_LONG_END: begin
            pred_phase = PH_IDLE;
            pred_hold_timer = '0;
            ev = EV_LONG_END;
         end
         PH_XLONG: begin
            if (!active) begin
               pred_phase = PH_XLONG_END;
               pred_hold_timer = '0;
            end
         end
         PH_XLONG_END: begin
            pred_phase = PH_IDLE;
            pred_hold_timer = '0;
            ev = EV_XLONG_END;
         end
         default: begin
            pred_phase = PH_IDLE;
         end
      endcase
      expected_class.push_back('{ev: ev, ph: pred_phase});
   endfunction

   task automatic check_class_word();
      press_class_type want;
      if (expected_class.size() == 0) begin
         report_mismatch("unexpected word, event_code", rsp_if.event_code, 0);
         return;
      end
      want = expected_class.pop_front();
      if (rsp_if.event_code !== want.ev)
         report_mismatch("event_code", rsp_if.event_code, want.ev);
      if (rsp_if.press_state !== want.ph)
         report_mismatch("press_state", rsp_if.press_state, want.ph);
   endtask

   always @(posedge clock) begin
      if (reset) begin
         pred_active_level = 1'b0;
         pred_release_hold = 16'd50;
         pred_long_press   = 16'd800;
         pred_extra_long   = 16'd0;
         pred_phase        = PH_IDLE;
         pred_hold_timer   = '0;
         expected_class.delete();
      end else begin
         if (csr_wr_en) begin
            case (csr_index)
               REG_ACTIVE_LEVEL: pred_active_level = csr_wdata[0];
               REG_RELEASE_HOLD: pred_release_hold = csr_wdata;
               REG_LONG_PRESS:   pred_long_press   = csr_wdata;
               REG_EXTRA_LONG:   pred_extra_long   = csr_wdata;
               default: ;
            endcase
         end
         if (req_if.valid && req_if.ready)
            classify_scan(req_if.switch_level, req_if.ms_elapsed);
         if (rsp_if.valid && rsp_if.ready)
            check_class_word();
      end
   end

   initial begin : rsp_stall
      int n;
      rsp_if.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (idle_on && $urandom_range(0, 5) == 0) begin
            n = $urandom_range(1, 7);
            rsp_if.ready <= 1'b0;
            repeat (n) @(posedge clock);
         end
         rsp_if.ready <= 1'b1;
      end
   end

   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (quiet < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if (reset || csr_wr_en || (req_if.valid && req_if.ready)
             || (rsp_if.valid && rsp_if.ready))
            quiet = 0;
         else
            quiet++;
      end
      $display("tb: failure");
      $finish;
   end

   task automatic send_scan(input logic level, input logic [ELAPSED_W-1:0] ms);
      int gap;
      if (idle_on && $urandom_range(0, 3) == 0) begin
         gap = $urandom_range(1, 7);
         req_if.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_if.valid        <= 1'b1;
      req_if.switch_level <= level;
      req_if.ms_elapsed   <= ms;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
   endtask

   task automatic drain_words();
      req_if.valid <= 1'b0;
      while (expected_class.size() != 0) @(posedge clock);
      repeat (2) @(posedge clock);
   endtask

   task automatic write_reg(input csr_index_type idx, input logic [CFG_W-1:0] value);
      drain_words();
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
   endtask

   function automatic logic [CFG_W-1:0] pick_threshold();
      case ($urandom_range(0, 7))
         0:       return 16'd0;
         1:       return 16'hFFFF;
         2, 3:    return CFG_W'($urandom_range(1, 200));
         default: return CFG_W'($urandom_range(200, 4000));
      endcase
   endfunction

   function automatic logic [ELAPSED_W-1:0] pick_elapsed();
      case ($urandom_range(0, 7))
         0:       return '0;
         1:       return '1;
         2, 3:    return ELAPSED_W'($urandom_range(0, 63));
         default: return ELAPSED_W'($urandom_range(0, 1023));
      endcase
   endfunction

   task automatic test_default_registers();
      send_scan(1'b1, 10'd5);
      send_scan(1'b0, 10'd0);
      send_scan(1'b0, 10'd800);
      send_scan(1'b0, 10'd1);
      send_scan(1'b0, 10'd1023);
      send_scan(1'b1, 10'd0);
      send_scan(1'b1, 10'd0);
      send_scan(1'b0, 10'd1023);
      send_scan(1'b1, 10'd1023);
      send_scan(1'b1, 10'd50);
      send_scan(1'b0, 10'd7);
      send_scan(1'b1, 10'd0);
   endtask

   task automatic test_extreme_registers();
      write_reg(REG_ACTIVE_LEVEL, 16'hFFFF);
      write_reg(REG_RELEASE_HOLD, 16'd0);
      write_reg(REG_LONG_PRESS, 16'd0);
      write_reg(REG_EXTRA_LONG, 16'd1);
      send_scan(1'b1, 10'd0);
      send_scan(1'b1, 10'd0);
      send_scan(1'b1, 10'd1);
      send_scan(1'b1, 10'd0);
      send_scan(1'b1, 10'd1);
      send_scan(1'b1, 10'd1023);
      send_scan(1'b0, 10'd1023);
      send_scan(1'b1, 10'd0);
      send_scan(1'b1, 10'd0);
      send_scan(1'b0, 10'd0);
      send_scan(1'b0, 10'd0);
      send_scan(1'b0, 10'd1);
   endtask

   task automatic test_timer_saturation();
      write_reg(REG_ACTIVE_LEVEL, 16'hFFFE);
      write_reg(REG_RELEASE_HOLD, 16'hFFFF);
      write_reg(REG_LONG_PRESS, 16'hFFFF);
      write_reg(REG_EXTRA_LONG, 16'd0);
      send_scan(1'b0, 10'd0);
      repeat (66) send_scan(1'b0, 10'd1023);
      send_scan(1'b1, 10'd0);
      repeat (66) send_scan(1'b1, 10'd1023);
      write_reg(REG_RELEASE_HOLD, 16'hFFFE);
      send_scan(1'b1, 10'd0);
      send_scan(1'b0, 10'd0);
      repeat (66) send_scan(1'b0, 10'd1023);
      write_reg(REG_LONG_PRESS, 16'hFFFE);
      send_scan(1'b0, 10'd0);
      send_scan(1'b1, 10'd0);
      send_scan(1'b1, 10'd0);
   endtask

   task automatic test_random_presses(input int n_words, input bit with_idle);
      int   sent;
      int   hold_n;
      int   rel_n;
      logic act;
      idle_on = with_idle;
      write_reg(REG_ACTIVE_LEVEL, CFG_W'($urandom()));
      write_reg(REG_RELEASE_HOLD, pick_threshold());
      write_reg(REG_LONG_PRESS, pick_threshold());
      write_reg(REG_EXTRA_LONG, ($urandom_range(0, 2) == 0) ? 16'd0 : pick_threshold());
      sent = 0;
      while (sent < n_words) begin
         if ($urandom_range(0, 6) == 0) begin
            send_scan(1'($urandom_range(0, 1)), pick_elapsed());
            sent++;
         end else begin
            act    = pred_active_level;
            hold_n = $urandom_range(1, 10);
            rel_n  = $urandom_range(1, 6);
            repeat (hold_n) send_scan(act, pick_elapsed());
            repeat (rel_n) send_scan(~act, pick_elapsed());
            sent += hold_n + rel_n;
         end
      end
   endtask

   initial begin
      reset               <= 1'b1;
      req_if.valid        <= 1'b0;
      req_if.switch_level <= 1'b0;
      req_if.ms_elapsed   <= '0;
      csr_wr_en           <= 1'b0;
      csr_index           <= REG_ACTIVE_LEVEL;
      csr_wdata           <= '0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_default_registers();
      test_extreme_registers();
      test_timer_saturation();
      test_random_presses(200, 1'b1);
      test_random_presses(200, 1'b0);
      test_random_presses(200, 1'b1);
      test_random_presses(200, 1'b1);
      test_random_presses(200, 1'b1);
      test_random_presses(210, 1'b0);

      drain_words();
      repeat (4) @(posedge clock);
      if (error_count == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

endmodule
